@@ sv/bhb_pkg.sv @@
package bhb_pkg;

    typedef enum logic [3:0] {
        S_LOAD,
        S_NODE,
        S_GETN,
        S_RDL,
        S_CMPL,
        S_CMPR,
        S_SWAP,
        S_SWAP2,
        S_NEXT,
        S_EMRD,
        S_EMIT
    } state_t;

    // True when a belongs above b: greater for a max-heap, smaller for a min-heap.
    function automatic logic ranks_above(
        input logic signed [31:0] a,
        input logic signed [31:0] b,
        input logic               min_heap
    );
        logic res;
        if (min_heap)
        begin
            res = (a < b);
        end
        else
        begin
            res = (a > b);
        end
        return res;
    endfunction

endpackage

@@ sv/binary_heap_build_core.sv @@
// Channel   | Signals                                  | Direction
// ----------+------------------------------------------+----------
// input     | in_valid, in_ready, element, last_element | in
// output    | out_valid, out_ready, heap_value, final_value | out
// config    | heap_order_we, heap_order                | in
//
// Loading accepts each offered item at once; the block stays ready until an item marked last.
// The build runs on one compare unit and one memory read port: each node is fetched, then
// at each level its children are read and compared and any swap is written back; a level
// with no swap ends the node. Fewer than N levels are sunk in all for N elements. After
// the build the first element is read, then one item leaves per cycle while out_ready is
// high. A stalled output holds its item; no input item is taken from the last one until
// the final result is delivered. Reset clears the count, the order bit and the state.

module binary_heap_build_core #(
    parameter int CAPACITY = 64
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               heap_order_we,
    input  logic               heap_order,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic signed [31:0] element,
    input  logic               last_element,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [31:0] heap_value,
    output logic               final_value
);

    localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int XW = IW + 2;

    bhb_pkg::state_t state_reg, state_next;

    logic [CW-1:0]      count_reg, count_next;
    logic               heap_order_reg;
    logic               order_reg, order_next;
    logic [IW-1:0]      node_reg, node_next;
    logic [IW-1:0]      build_reg, build_next;
    logic [IW-1:0]      emit_reg, emit_next;
    logic [IW-1:0]      best_idx_reg, best_idx_next;
    logic signed [31:0] node_val_reg, node_val_next;
    logic signed [31:0] best_val_reg, best_val_next;
    logic signed [31:0] rd_data_reg;

    logic signed [31:0] element_store [CAPACITY];

    logic               wr_en;
    logic [IW-1:0]      wr_addr;
    logic signed [31:0] wr_data;
    logic [IW-1:0]      rd_addr;

    logic               in_acc;
    logic               out_acc;
    logic               full;
    logic [CW-1:0]      n_new;
    logic [CW-1:0]      half;
    logic [XW-1:0]      left_x;
    logic [XW-1:0]      right_x;
    logic [XW-1:0]      n_x;
    logic               has_left;
    logic               has_right;
    logic               is_final;
    logic               child_wins;

    assign in_acc     = in_valid && in_ready;
    assign out_acc    = out_valid && out_ready;
    assign full       = (count_reg == CW'(CAPACITY));
    assign n_new      = full ? count_reg : CW'(count_reg + 1'b1);
    assign half       = n_new >> 1;
    assign left_x     = XW'({node_reg, 1'b1});
    assign right_x    = XW'(left_x + 1'b1);
    assign n_x        = XW'(count_reg);
    assign has_left   = (left_x < n_x);
    assign has_right  = (right_x < n_x);
    assign is_final   = (XW'(XW'(emit_reg) + 1'b1) == n_x);
    assign child_wins = bhb_pkg::ranks_above(rd_data_reg, best_val_reg, order_reg);

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            bhb_pkg::S_LOAD:
            begin
                if (in_acc && last_element)
                begin
                    state_next = (half == '0) ? bhb_pkg::S_EMRD : bhb_pkg::S_NODE;
                end
            end
            bhb_pkg::S_NODE:  state_next = bhb_pkg::S_GETN;
            bhb_pkg::S_GETN:  state_next = bhb_pkg::S_RDL;
            bhb_pkg::S_RDL:   state_next = has_left ? bhb_pkg::S_CMPL : bhb_pkg::S_NEXT;
            bhb_pkg::S_CMPL:  state_next = has_right ? bhb_pkg::S_CMPR : bhb_pkg::S_SWAP;
            bhb_pkg::S_CMPR:  state_next = bhb_pkg::S_SWAP;
            bhb_pkg::S_SWAP:
            begin
                state_next = (best_idx_reg == node_reg) ? bhb_pkg::S_NEXT : bhb_pkg::S_SWAP2;
            end
            bhb_pkg::S_SWAP2: state_next = bhb_pkg::S_RDL;
            bhb_pkg::S_NEXT:
            begin
                state_next = (build_reg == '0) ? bhb_pkg::S_EMRD : bhb_pkg::S_NODE;
            end
            bhb_pkg::S_EMRD:  state_next = bhb_pkg::S_EMIT;
            bhb_pkg::S_EMIT:
            begin
                if (out_acc && is_final)
                begin
                    state_next = bhb_pkg::S_LOAD;
                end
            end
            default:          state_next = bhb_pkg::S_LOAD;
        endcase
    end

    // Handshake and memory port controls.
    always_comb
    begin
        in_ready  = 1'b0;
        out_valid = 1'b0;
        wr_en     = 1'b0;
        wr_addr   = node_reg;
        wr_data   = best_val_reg;
        rd_addr   = node_reg;
        unique case (state_reg)
            bhb_pkg::S_LOAD:
            begin
                in_ready = 1'b1;
                wr_en    = in_acc && !full;
                wr_addr  = IW'(count_reg);
                wr_data  = element;
            end
            bhb_pkg::S_RDL:   rd_addr = IW'(left_x);
            bhb_pkg::S_CMPL:  rd_addr = IW'(right_x);
            bhb_pkg::S_SWAP:  wr_en = (best_idx_reg != node_reg);
            bhb_pkg::S_SWAP2:
            begin
                wr_en   = 1'b1;
                wr_addr = best_idx_reg;
                wr_data = node_val_reg;
            end
            bhb_pkg::S_EMRD:  rd_addr = '0;
            bhb_pkg::S_EMIT:
            begin
                out_valid = 1'b1;
                rd_addr   = (out_acc && !is_final) ? IW'(emit_reg + 1'b1) : emit_reg;
            end
            default:          rd_addr = node_reg;
        endcase
    end

    // Datapath registers.
    always_comb
    begin
        count_next    = count_reg;
        order_next    = order_reg;
        node_next     = node_reg;
        build_next    = build_reg;
        emit_next     = emit_reg;
        best_idx_next = best_idx_reg;
        best_val_next = best_val_reg;
        node_val_next = node_val_reg;
        case (state_reg)
            bhb_pkg::S_LOAD:
            begin
                if (in_acc)
                begin
                    count_next = n_new;
                    if (last_element)
                    begin
                        order_next = heap_order_reg;
                        build_next = IW'(half - 1'b1);
                        node_next  = IW'(half - 1'b1);
                    end
                end
            end
            bhb_pkg::S_GETN: node_val_next = rd_data_reg;
            bhb_pkg::S_RDL:
            begin
                best_val_next = node_val_reg;
                best_idx_next = node_reg;
            end
            bhb_pkg::S_CMPL:
            begin
                if (child_wins)
                begin
                    best_val_next = rd_data_reg;
                    best_idx_next = IW'(left_x);
                end
            end
            bhb_pkg::S_CMPR:
            begin
                if (child_wins)
                begin
                    best_val_next = rd_data_reg;
                    best_idx_next = IW'(right_x);
                end
            end
            bhb_pkg::S_SWAP2: node_next = best_idx_reg;
            bhb_pkg::S_NEXT:
            begin
                build_next = IW'(build_reg - 1'b1);
                node_next  = IW'(build_reg - 1'b1);
            end
            bhb_pkg::S_EMRD: emit_next = '0;
            bhb_pkg::S_EMIT:
            begin
                if (out_acc)
                begin
                    if (is_final)
                    begin
                        count_next = '0;
                    end
                    else
                    begin
                        emit_next = IW'(emit_reg + 1'b1);
                    end
                end
            end
            default:
            begin
                count_next = count_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= bhb_pkg::S_LOAD;
            count_reg      <= '0;
            heap_order_reg <= 1'b0;
            order_reg      <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            order_reg <= order_next;
            if (heap_order_we)
            begin
                heap_order_reg <= heap_order;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        node_reg     <= node_next;
        build_reg    <= build_next;
        emit_reg     <= emit_next;
        best_idx_reg <= best_idx_next;
        best_val_reg <= best_val_next;
        node_val_reg <= node_val_next;
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            element_store[wr_addr] <= wr_data;
        end
        rd_data_reg <= element_store[rd_addr];
    end

    assign heap_value  = rd_data_reg;
    assign final_value = is_final;

endmodule

@@ sv/bhb_checker.sv @@
module bhb_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               in_valid,
    input logic               in_ready,
    input logic               last_element,
    input logic               out_valid,
    input logic               out_ready,
    input logic signed [31:0] heap_value,
    input logic               final_value
);

    // A stalled result item holds.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(heap_value) && $stable(final_value))
        else $error("stalled result item changed");

    // The block never takes input while it shows results.
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !in_ready)
        else $error("input ready while emitting");

    // An item marked last closes the input until the heap is delivered.
    a_last_closes: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && last_element |=> !in_ready)
        else $error("input still ready after last item");

    // Delivering the final result reopens the input.
    a_final_reopens: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && final_value |=> in_ready && !out_valid)
        else $error("input not ready after final result");

endmodule

bind binary_heap_build_core bhb_checker u_bhb_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .last_element (last_element),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .heap_value   (heap_value),
    .final_value  (final_value)
);

@@ sim/testbench.sv @@
module testbench;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int          CAPACITY      = 64;
    localparam bit          MAX_HEAP      = 1'b0;
    localparam bit          MIN_HEAP      = 1'b1;
    localparam int          CYCLE_LIMIT   = 200000;
    localparam int          SETTLE_CYCLES = 20;
    localparam int          RANDOM_ITEMS  = 8;
    localparam logic [31:0] MOST_NEGATIVE = 32'h8000_0000;
    localparam logic [31:0] MOST_POSITIVE = 32'h7fff_ffff;

    typedef struct {
        logic signed [31:0] value;
        logic               is_final;
    } heap_entry_t;

    logic               clk;
    logic               rst_n;
    logic               heap_order_we;
    logic               heap_order;
    logic               in_valid;
    logic               in_ready;
    logic signed [31:0] element;
    logic               last_element;
    logic               out_valid;
    logic               out_ready;
    logic signed [31:0] heap_value;
    logic               final_value;

    logic signed [31:0] heap_store [CAPACITY];
    int unsigned        loaded_count;
    bit                 order_is_min;
    heap_entry_t        expected_heap [$];

    int                 mismatch_count;
    int                 cycle_count;
    int                 stall_cycles;
    bit                 tx_steady;
    bit                 rx_steady;

    binary_heap_build_core #(
        .CAPACITY(CAPACITY)
    ) DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .heap_order_we(heap_order_we),
        .heap_order   (heap_order),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .element      (element),
        .last_element (last_element),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .heap_value   (heap_value),
        .final_value  (final_value)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic bit belongs_above(logic signed [31:0] a, logic signed [31:0] b);
        if (order_is_min)
        begin
            return a < b;
        end
        return a > b;
    endfunction

    function automatic void sift_down(int unsigned start, int unsigned n);
        int unsigned        node;
        int unsigned        best;
        int unsigned        left;
        int unsigned        right;
        logic signed [31:0] held;
        bit                 settled;
        node = start;
        settled = 1'b0;
        while (!settled)
        begin
            best = node;
            left = 2 * node + 1;
            right = 2 * node + 2;
            if (left < n && belongs_above(heap_store[left], heap_store[best]))
            begin
                best = left;
            end
            if (right < n && belongs_above(heap_store[right], heap_store[best]))
            begin
                best = right;
            end
            if (best == node)
            begin
                settled = 1'b1;
            end
            else
            begin
                held = heap_store[best];
                heap_store[best] = heap_store[node];
                heap_store[node] = held;
                node = best;
            end
        end
    endfunction

    // Stores one accepted element and, on the last one, predicts the whole emitted heap.
    function automatic void absorb_element(logic signed [31:0] value, logic is_last);
        int unsigned n;
        heap_entry_t entry;
        if (loaded_count < CAPACITY)
        begin
            heap_store[loaded_count] = value;
            loaded_count++;
        end
        if (is_last)
        begin
            n = loaded_count;
            for (int i = n / 2; i > 0; i--)
            begin
                sift_down(i - 1, n);
            end
            for (int i = 0; i < n; i++)
            begin
                entry.value = heap_store[i];
                entry.is_final = (i + 1 == n);
                expected_heap.push_back(entry);
            end
            loaded_count = 0;
        end
    endfunction

    function automatic int pick_gap(bit steady);
        int roll;
        if (steady)
        begin
            return 0;
        end
        roll = $urandom_range(0, 99);
        if (roll < 55)
        begin
            return 0;
        end
        if (roll < 90)
        begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    function automatic void note_error(string what);
        mismatch_count++;
        if (mismatch_count <= 10)
        begin
            $display("ERROR at cycle %0d: %s", cycle_count, what);
        end
    endfunction

    // Every task below is entered and left at a falling edge.
    task automatic send_element(input logic signed [31:0] value, input logic is_last);
        int gap;
        gap = pick_gap(tx_steady);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        element <= value;
        last_element <= is_last;
        @(posedge clk);
        while (!in_ready)
        begin
            @(posedge clk);
        end
        absorb_element(value, is_last);
        @(negedge clk);
    endtask

    task automatic send_list(input int length, input int flavor);
        logic signed [31:0] value;
        for (int i = 0; i < length; i++)
        begin
            case (flavor)
                0: value = $urandom;
                1: value = $signed($urandom_range(0, 8)) - 4;
                default:
                begin
                    case ($urandom_range(0, 4))
                        0: value = MOST_NEGATIVE;
                        1: value = MOST_POSITIVE;
                        2: value = 0;
                        3: value = -1;
                        default: value = $urandom;
                    endcase
                end
            endcase
            send_element(value, i == length - 1);
        end
    endtask

    task automatic drain_heap();
        in_valid <= 1'b0;
        while (expected_heap.size() != 0)
        begin
            @(negedge clk);
        end
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic set_heap_order(input bit mode);
        heap_order_we <= 1'b1;
        heap_order <= mode;
        @(negedge clk);
        heap_order_we <= 1'b0;
        order_is_min = mode;
    endtask

    task automatic test_single_element();
        set_heap_order(MAX_HEAP);
        send_element(MOST_POSITIVE, 1'b1);
        drain_heap();
        set_heap_order(MIN_HEAP);
        send_element(MOST_NEGATIVE, 1'b1);
        drain_heap();
    endtask

    task automatic test_extreme_values();
        set_heap_order(MAX_HEAP);
        send_element(MOST_NEGATIVE, 1'b0);
        send_element(MOST_POSITIVE, 1'b0);
        send_element(0, 1'b0);
        send_element(-1, 1'b0);
        send_element(1, 1'b1);
        drain_heap();
        set_heap_order(MIN_HEAP);
        send_element(MOST_POSITIVE, 1'b0);
        send_element(1, 1'b0);
        send_element(-1, 1'b0);
        send_element(0, 1'b0);
        send_element(MOST_NEGATIVE, 1'b1);
        drain_heap();
    endtask

    // Equal keys check that only a strictly better child is swapped up, left before right.
    task automatic test_equal_keys();
        set_heap_order(MAX_HEAP);
        send_element(5, 1'b0);
        send_element(7, 1'b0);
        send_element(7, 1'b0);
        send_element(5, 1'b0);
        send_element(5, 1'b1);
        drain_heap();
        set_heap_order(MIN_HEAP);
        send_element(3, 1'b0);
        send_element(1, 1'b0);
        send_element(1, 1'b0);
        send_element(3, 1'b1);
        drain_heap();
    endtask

    // The store fills up and the last mark arrives on an element that is dropped.
    task automatic test_full_store();
        set_heap_order(MIN_HEAP);
        for (int i = 0; i < CAPACITY + 2; i++)
        begin
            send_element($urandom, i == CAPACITY + 1);
        end
        drain_heap();
    endtask

    // The output is held off while a second list is offered, so the input stalls.
    task automatic test_output_stall();
        tx_steady = 1'b1;
        stall_cycles = 400;
        send_list(10, 0);
        send_list(10, 1);
        drain_heap();
        tx_steady = 1'b0;
    endtask

    task automatic test_random_lists();
        int sent;
        int length;
        sent = 0;
        while (sent < RANDOM_ITEMS)
        begin
            tx_steady = ($urandom_range(0, 3) == 0);
            rx_steady = ($urandom_range(0, 3) == 0);
            if ($urandom_range(0, 4) == 0)
            begin
                drain_heap();
                set_heap_order(1'($urandom_range(0, 1)));
            end
            length = $urandom_range(1, 6);
            if (length > RANDOM_ITEMS - sent)
            begin
                length = RANDOM_ITEMS - sent;
            end
            send_list(length, $urandom_range(0, 2));
            sent += length;
        end
        drain_heap();
        tx_steady = 1'b0;
        rx_steady = 1'b0;
    endtask

    initial
    begin
        int idle_left;
        idle_left = 0;
        out_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (stall_cycles > 0)
            begin
                out_ready <= 1'b0;
                stall_cycles--;
            end
            else if (idle_left > 0)
            begin
                out_ready <= 1'b0;
                idle_left--;
            end
            else
            begin
                out_ready <= 1'b1;
                idle_left = pick_gap(rx_steady);
            end
        end
    end

    always @(posedge clk)
    begin : check_heap
        heap_entry_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_heap.size() == 0)
            begin
                note_error($sformatf("unexpected item, heap_value %0d final_value %0b",
                                     heap_value, final_value));
            end
            else
            begin
                want = expected_heap.pop_front();
                if (heap_value !== want.value)
                begin
                    note_error($sformatf("heap_value expected %0d, got %0d",
                                         want.value, heap_value));
                end
                if (final_value !== want.is_final)
                begin
                    note_error($sformatf("final_value expected %0b, got %0b",
                                         want.is_final, final_value));
                end
            end
        end
    end

    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("binary_heap_build_core: mismatch");
        $finish;
    end

    initial
    begin
        rst_n = 1'b0;
        heap_order_we = 1'b0;
        heap_order = 1'b0;
        in_valid = 1'b0;
        element = '0;
        last_element = 1'b0;
        loaded_count = 0;
        order_is_min = MAX_HEAP;
        mismatch_count = 0;
        stall_cycles = 0;
        tx_steady = 1'b0;
        rx_steady = 1'b0;
        for (int i = 0; i < CAPACITY; i++)
        begin
            heap_store[i] = '0;
        end
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_single_element();
        test_extreme_values();
        test_equal_keys();
        test_full_store();
        test_output_stall();
        test_random_lists();

        if (mismatch_count == 0)
        begin
            $display("binary_heap_build_core: match");
        end
        else
        begin
            $display("binary_heap_build_core: mismatch");
        end
        $finish;
    end

endmodule
